// ===== hw/rtl/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the TGA RLE pixel decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BPP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [2:0]  BPP_RESET    = 3'd4;
	localparam logic [15:0] WIDTH_RESET  = 16'd1;
	localparam logic [15:0] HEIGHT_RESET = 16'd1;

	// Packet header decoding
	localparam int          HDR_RUN_BIT = 7;
	localparam logic [6:0]  HDR_COUNT_MASK = 7'h7F;

	// Gathered pixel bytes held ahead of the final byte
	localparam int GATHER_BYTES = 3;
	localparam int GATHER_W     = 8 * GATHER_BYTES;
	localparam int VALUE_BYTES  = 4;

	typedef enum logic {
		PH_HEADER,
		PH_PIXEL
	} trd_phase_t;

	// Configuration seen by the parser
	typedef struct packed {
		logic [31:0] image_size;
		logic        restart;
	} trd_cfg_t;

	// One decoded pixel travelling from parser to output stage
	typedef struct packed {
		logic [GATHER_W-1:0] gather;
		logic [7:0]          last_byte;
		logic [1:0]          lane;
		logic                lane_ok;
		logic [7:0]          repeat_count;
		logic                image_done;
	} trd_entry_t;

endpackage

// ===== hw/rtl/trd_cfg.sv =====
// ----------------------------------------------------------------------------
// trd_cfg
// Configuration registers, clamped pixel size and image size product.
// ----------------------------------------------------------------------------
module trd_cfg import trd_pkg::*; #(
	parameter int MAX_PIXEL_BYTES = 4,
	parameter int PSZ_W = $clog2(MAX_PIXEL_BYTES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [PSZ_W-1:0]      psize,
	output trd_cfg_t              cfg
);

	logic [2:0]  bpp_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] size_q;
	logic        restart_q;

	logic        idx_ok;
	logic [15:0] width_d;
	logic [15:0] height_d;
	logic [15:0] w_eff;
	logic [15:0] h_eff;
	logic [31:0] bpp_ext;

	always_comb begin
		idx_ok   = 1'b0;
		width_d  = width_q;
		height_d = height_q;
		unique case (cfg_index)
			CFG_IDX_BPP:    idx_ok = 1'b1;
			CFG_IDX_WIDTH: begin
				idx_ok  = 1'b1;
				width_d = cfg_data;
			end
			CFG_IDX_HEIGHT: begin
				idx_ok   = 1'b1;
				height_d = cfg_data;
			end
			default:        idx_ok = 1'b0;
		endcase
		// treat a zero dimension as one
		w_eff = (width_d == 16'd0) ? 16'd1 : width_d;
		h_eff = (height_d == 16'd0) ? 16'd1 : height_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q     <= BPP_RESET;
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			size_q    <= 32'd1;
			restart_q <= 1'b0;
		end else begin
			restart_q <= cfg_wr && idx_ok;
			if (cfg_wr && idx_ok) begin
				if (cfg_index == CFG_IDX_BPP)
					bpp_q <= cfg_data[2:0];
				width_q  <= width_d;
				height_q <= height_d;
				size_q   <= w_eff * h_eff;
			end
		end
	end

	// clamp the pixel size into 1..MAX_PIXEL_BYTES
	always_comb begin
		bpp_ext = 32'(bpp_q);
		if (bpp_ext == 32'd0)
			psize = PSZ_W'(1);
		else if (bpp_ext > 32'(MAX_PIXEL_BYTES))
			psize = PSZ_W'(MAX_PIXEL_BYTES);
		else
			psize = PSZ_W'(bpp_ext);
	end

	assign cfg.image_size = size_q;
	assign cfg.restart    = restart_q;

endmodule

// ===== hw/rtl/trd_front.sv =====
// ----------------------------------------------------------------------------
// trd_front
// Byte parser: packet headers, pixel gathering, image pixel accounting.
// ----------------------------------------------------------------------------
module trd_front import trd_pkg::*; #(
	parameter int MAX_PIXEL_BYTES = 4,
	parameter int PSZ_W = $clog2(MAX_PIXEL_BYTES + 1),
	parameter int BIP_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic [PSZ_W-1:0] psize,
	input  trd_cfg_t         cfg,
	input  logic             q_full,
	output logic             push,
	output trd_entry_t       entry
);

	trd_phase_t          phase_q, phase_d;
	logic [BIP_W-1:0]    bip_q, bip_d;
	logic [GATHER_W-1:0] gather_q, gather_d;
	logic [7:0]          pkt_q, pkt_d;
	logic                run_q, run_d;
	logic [31:0]         left_q, left_d;

	logic        accept;
	logic        last_byte;
	logic [7:0]  rep_raw;
	logic [7:0]  rep_clamp;
	logic        covers;
	logic [31:0] left_after;
	logic [7:0]  pkt_after;

	assign in_ready = !q_full && !cfg.restart;
	assign accept   = in_valid && in_ready;

	always_comb begin
		last_byte  = (32'(bip_q) + 32'd1) >= 32'(psize);
		rep_raw    = run_q ? pkt_q : 8'd1;
		covers     = {24'd0, rep_raw} >= left_q;
		rep_clamp  = covers ? left_q[7:0] : rep_raw;
		left_after = left_q - {24'd0, rep_clamp};
		pkt_after  = run_q ? 8'd0 : (pkt_q - 8'd1);
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		bip_d    = bip_q;
		gather_d = gather_q;
		pkt_d    = pkt_q;
		run_d    = run_q;
		left_d   = left_q;
		if (cfg.restart) begin
			phase_d  = PH_HEADER;
			bip_d    = '0;
			gather_d = '0;
			pkt_d    = 8'd0;
			run_d    = 1'b0;
			left_d   = cfg.image_size;
		end else if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					pkt_d    = {1'b0, in_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
					run_d    = in_byte[HDR_RUN_BIT];
					bip_d    = '0;
					gather_d = '0;
					phase_d  = PH_PIXEL;
				end
				PH_PIXEL: begin
					if (!last_byte) begin
						for (int k = 0; k < GATHER_BYTES; k++) begin
							if (32'(bip_q) == k)
								gather_d[8*k +: 8] = in_byte;
						end
						bip_d = bip_q + BIP_W'(1);
					end else begin
						bip_d    = '0;
						gather_d = '0;
						if (covers) begin
							// image complete: drop the rest of the packet
							phase_d = PH_HEADER;
							pkt_d   = 8'd0;
							run_d   = 1'b0;
							left_d  = cfg.image_size;
						end else begin
							pkt_d  = pkt_after;
							left_d = left_after;
							if (pkt_after == 8'd0)
								phase_d = PH_HEADER;
						end
					end
				end
				default: phase_d = PH_HEADER;
			endcase
		end
	end

	// outputs
	always_comb begin
		push               = accept && (phase_q == PH_PIXEL) && last_byte;
		entry.gather       = gather_q;
		entry.last_byte    = in_byte;
		entry.lane         = 2'(bip_q);
		entry.lane_ok      = 32'(bip_q) < 32'(VALUE_BYTES);
		entry.repeat_count = rep_clamp;
		entry.image_done   = covers;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			bip_q    <= '0;
			gather_q <= '0;
			pkt_q    <= 8'd0;
			run_q    <= 1'b0;
			left_q   <= 32'd1;
		end else begin
			phase_q  <= phase_d;
			bip_q    <= bip_d;
			gather_q <= gather_d;
			pkt_q    <= pkt_d;
			run_q    <= run_d;
			left_q   <= left_d;
		end
	end

endmodule

// ===== hw/rtl/trd_queue.sv =====
// ----------------------------------------------------------------------------
// trd_queue
// Two-entry queue between parser and output stage.
// ----------------------------------------------------------------------------
module trd_queue import trd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  trd_entry_t push_entry,
	output logic       full,
	output logic       q_valid,
	input  logic       pop_ready,
	output trd_entry_t head
);

	trd_entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = count_q == 2'd2;
	assign q_valid = count_q != 2'd0;
	assign do_push = push && !full;
	assign do_pop  = q_valid && pop_ready;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/trd_back.sv =====
// ----------------------------------------------------------------------------
// trd_back
// Output stage: assemble the pixel word and hold the result for the receiver.
// ----------------------------------------------------------------------------
module trd_back import trd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_ready,
	input  trd_entry_t head,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [31:0] pixel_value,
	output logic [7:0]  repeat_count,
	output logic        image_done
);

	logic        out_valid_q;
	logic [31:0] value_q;
	logic [7:0]  repeat_q;
	logic        done_q;
	logic [31:0] value_d;
	logic        load;

	assign q_ready = !out_valid_q || out_ready;
	assign load    = q_valid && q_ready;

	always_comb begin
		value_d = {8'd0, head.gather};
		if (head.lane_ok)
			value_d = value_d | (32'(head.last_byte) << (8 * head.lane));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q  <= value_d;
			repeat_q <= head.repeat_count;
			done_q   <= head.image_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_ready)
			out_valid_q <= q_valid;
	end

	assign out_valid    = out_valid_q;
	assign pixel_value  = value_q;
	assign repeat_count = repeat_q;
	assign image_done   = done_q;

endmodule

// ===== hw/rtl/tga_rle_pixel_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Targa RLE stream decoder: one encoded byte in, one pixel request out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes the encoded stream, one
//   byte per request: a packet header, then the pixel bytes of the packet.
//   Output channel (out_valid/out_ready) returns one request per completed
//   pixel: pixel_value (first stream byte in bits 7:0), repeat_count (run
//   length, or 1 for a raw pixel, clamped to the pixels left in the image)
//   and image_done on the pixel that completes width*height pixels.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   bytes_per_pixel (0), image_width (1) and image_height (2); a write to a
//   known register restarts decoding at a new image. Write only while idle.
//   Throughput: one byte per cycle while in_ready is high. The byte that
//   completes a pixel writes the queue, and the output register loads the
//   pixel from the queue, raising out_valid, when it is empty or its
//   request is being taken.
//   A stalled receiver fills the output register and then the two-entry
//   queue, after which in_ready drops. in_ready also drops for the one cycle
//   in which a configuration write reloads the parser.
//   Reset: 4 bytes per pixel, 1x1 image, header expected, no request held.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top import trd_pkg::*; #(
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           pixel_value,
	output logic [7:0]            repeat_count,
	output logic                  image_done
);

	localparam int PSZ_W = $clog2(MAX_PIXEL_BYTES + 1);

	logic [PSZ_W-1:0] psize;
	trd_cfg_t         cfg;
	logic             q_full;
	logic             push;
	trd_entry_t       push_entry;
	logic             q_valid;
	logic             q_ready;
	trd_entry_t       head;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	trd_cfg #(
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
		.PSZ_W(PSZ_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.psize    (psize),
		.cfg      (cfg)
	);

	// front: classify each byte, gather pixels, count image pixels
	trd_front #(
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
		.PSZ_W(PSZ_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte (in_byte),
		.psize   (psize),
		.cfg     (cfg),
		.q_full  (q_full),
		.push    (push),
		.entry   (push_entry)
	);

	// decouple the parser from receiver stalls
	trd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.q_valid   (q_valid),
		.pop_ready (q_ready),
		.head      (head)
	);

	// back: assemble the pixel word and hold it for the receiver
	trd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.head        (head),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_value (pixel_value),
		.repeat_count(repeat_count),
		.image_done  (image_done)
	);

endmodule
